// ===== rtl/core/gcbep_pkg.sv =====
package gcbep_pkg;

  // Store geometry.
  localparam int NUM_BINS  = 26;
  localparam int BIN_DEPTH = 4096;

  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int IDX_W   = $clog2(BIN_DEPTH);
  localparam int CNT_W   = $clog2(BIN_DEPTH + 1);
  localparam int ADDR_W  = BIN_W + IDX_W;
  localparam int STORE_DEPTH = NUM_BINS * BIN_DEPTH;

  // Sample and result widths.
  localparam int SAMPLE_W = 16;
  localparam int PVAL_W   = 17;
  localparam int MINBG_W  = 8;

  // Q16 constants.
  localparam logic [PVAL_W-1:0] P_ONE  = PVAL_W'(65536);
  localparam logic [PVAL_W-1:0] P_HALF = PVAL_W'(32768);
  localparam logic [PVAL_W-1:0] P_ZERO = '0;

  // Register reset values.
  localparam logic [MINBG_W-1:0] MIN_BG_RESET = MINBG_W'(10);
  localparam logic [4:0]         SPLIT_RESET  = 5'd13;

  // Input item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [4:0] gc_count;
    logic [15:0] intensity;
  } in_item_t;

  typedef struct packed {
    logic [16:0] p_value;
    logic [4:0]  bin_used;
    logic [12:0] bin_population;
  } out_item_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PVAL_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/gcbep_bg_ram.sv =====
module gcbep_bg_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/gcbep_q16_div.sv =====
module gcbep_q16_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gcbep_pkg::div_req_t req,
  output gcbep_pkg::div_rsp_t rsp
);
  import gcbep_pkg::*;

  localparam int REM_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(PVAL_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PVAL_W - 1);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [PVAL_W-1:0] quot_r, quot_nxt;
  logic              done_r, done_nxt;

  logic [REM_W-1:0]  rem_cur;
  logic              take;

  // Restoring division: the first step yields the integer bit, the rest the
  // sixteen fraction bits of num/den, one bit a cycle.
  always_comb begin
    rem_cur  = (step_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    take     = rem_cur >= {1'b0, den_r};
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = {1'b0, req.num};
      den_nxt  = req.den;
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = take ? (rem_cur - {1'b0, den_r}) : rem_cur;
      quot_nxt = {quot_r[PVAL_W-2:0], take};
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== rtl/core/gc_binned_empirical_pvalue_core.sv =====
// GC-binned empirical detection p-value core.
// Input channel (in_valid/in_stall/in_data): a load item stores a 16-bit
// background sample in the bin chosen by gc_count; a query item asks for the
// Q16 p-value of an intensity against the background of that GC bin.
// Result channel (out_valid/out_stall/out_data): one result per query, none
// per load. Items leave in the order they were accepted.
// Configuration: APB-style write/read of min_background (address 0) and
// search_split_bin (address 4); write only while the core is idle.
// Loads can arrive every cycle while no query is in progress. A query steps
// through S search steps (one bin per cycle, at most NUM_BINS-1), streams the
// C samples (up to 4096) of the used bin from the sample memory, runs the
// bit-serial Q16 divider and passes through the control states. A bin below
// min_background skips the divider; an empty bin skips the streaming as well.
// A query holds the input stalled until its result enters the output register.
// The result sits in an output register; the core takes the next item while
// a finished result waits there. If the receiver stalls, a second finished
// query holds in its final state until the register frees.
// Reset (rst_n low, synchronous) empties all bins and restores the
// registers to 10 and 13; the sample memory itself is not cleared.
module gc_binned_empirical_pvalue_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gcbep_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gcbep_pkg::out_item_t out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import gcbep_pkg::*;

  localparam logic REG_MIN_BG = 1'b0;
  localparam logic REG_SPLIT  = 1'b1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam logic [BIN_W-1:0] TOP_BIN = BIN_W'(NUM_BINS - 1);
  localparam logic [CNT_W-1:0] FULL    = CNT_W'(BIN_DEPTH);

  // Configuration registers.
  logic [MINBG_W-1:0] min_bg_r;
  logic [4:0]         split_r;
  logic               cfg_wr;

  // Bin populations.
  logic [CNT_W-1:0] counts_r [NUM_BINS];

  // Query state.
  logic [2:0]          state_r, state_nxt;
  logic [BIN_W-1:0]    bin_r, bin_nxt;
  logic [SAMPLE_W-1:0] inten_r, inten_nxt;
  logic                upward_r, upward_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                minmode_r, minmode_nxt;
  logic [CNT_W-1:0]    iss_r, iss_nxt;
  logic [CNT_W-1:0]    rcv_r, rcv_nxt;
  logic                rv_r, rv_nxt;
  logic [SAMPLE_W-1:0] mn_r, mn_nxt;
  logic [CNT_W-1:0]    rank_r, rank_nxt;
  logic [PVAL_W-1:0]   p_r, p_nxt;

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_load;

  logic             accept;
  logic [BIN_W-1:0] in_bin;
  logic [CNT_W-1:0] in_cnt;
  logic             load_wr;
  logic [CNT_W-1:0] cur_cnt;
  logic             cur_low;
  logic [CNT_W-1:0] rank_cap;

  logic                ram_re;
  logic [SAMPLE_W-1:0] ram_rdata;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bg_r <= MIN_BG_RESET;
      split_r  <= SPLIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_MIN_BG: min_bg_r <= cfg_pwdata[MINBG_W-1:0];
        REG_SPLIT:  split_r  <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_MIN_BG: cfg_prdata = {{(32-MINBG_W){1'b0}}, min_bg_r};
      REG_SPLIT:  cfg_prdata = {27'd0, split_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // Input decode: out-of-range GC counts go to the top bin.
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_bin   = (32'(in_data.gc_count) >= NUM_BINS) ? TOP_BIN
                                                       : in_data.gc_count[BIN_W-1:0];
  assign in_cnt   = counts_r[in_bin];
  assign load_wr  = accept && (in_data.kind == KIND_LOAD) && (in_cnt != FULL);

  // Bin populations grow by one per stored sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        counts_r[i] <= '0;
      end
    end else if (load_wr) begin
      counts_r[in_bin] <= in_cnt + 1'b1;
    end
  end

  // Sample memory: loads write at the accept edge, queries stream one bin.
  assign ram_re = (state_r == ST_SCAN) && (iss_r < cnt_r);

  gcbep_bg_ram #(
    .DATA_W (SAMPLE_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_bg_ram (
    .clk   (clk),
    .we    (load_wr),
    .waddr ({in_bin, in_cnt[IDX_W-1:0]}),
    .wdata (in_data.intensity),
    .re    (ram_re),
    .raddr ({bin_r, iss_r[IDX_W-1:0]}),
    .rdata (ram_rdata)
  );

  // Rank capped at population minus one.
  assign rank_cap = (rank_r == cnt_r) ? (cnt_r - 1'b1) : rank_r;

  assign div_req.start = (state_r == ST_FINISH) && !minmode_r;
  assign div_req.num   = cnt_r - rank_cap;
  assign div_req.den   = cnt_r;

  gcbep_q16_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cur_cnt  = counts_r[bin_r];
  assign cur_low  = cur_cnt < {{(CNT_W-MINBG_W){1'b0}}, min_bg_r};
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Query sequencer.
  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    inten_nxt   = inten_r;
    upward_nxt  = upward_r;
    cnt_nxt     = cnt_r;
    minmode_nxt = minmode_r;
    iss_nxt     = iss_r;
    rcv_nxt     = rcv_r;
    rv_nxt      = 1'b0;
    mn_nxt      = mn_r;
    rank_nxt    = rank_r;
    p_nxt       = p_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.kind == KIND_QUERY)) begin
          bin_nxt    = in_bin;
          inten_nxt  = in_data.intensity;
          upward_nxt = 32'(in_bin) < 32'(split_r);
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // Step one neighbor bin a cycle while the bin is under-populated.
        if (cur_low && (bin_r != '0) && !(upward_r && (bin_r == TOP_BIN))) begin
          bin_nxt = upward_r ? (bin_r + 1'b1) : (bin_r - 1'b1);
        end else begin
          cnt_nxt     = cur_cnt;
          minmode_nxt = cur_low;
          iss_nxt     = '0;
          rcv_nxt     = '0;
          rank_nxt    = '0;
          if (cur_cnt == '0) begin
            p_nxt     = P_ZERO;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue one read a cycle; fold each returned sample into min and rank.
        if (ram_re) begin
          iss_nxt = iss_r + 1'b1;
        end
        rv_nxt = ram_re;
        if (rv_r) begin
          if ((rcv_r == '0) || (ram_rdata < mn_r)) begin
            mn_nxt = ram_rdata;
          end
          if (ram_rdata < inten_r) begin
            rank_nxt = rank_r + 1'b1;
          end
          rcv_nxt = rcv_r + 1'b1;
          if (rcv_r == (cnt_r - 1'b1)) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        // Small bins compare against their minimum; others go to the divider.
        if (minmode_r) begin
          if (inten_r < mn_r) begin
            p_nxt = P_ONE;
          end else if (inten_r > mn_r) begin
            p_nxt = P_ZERO;
          end else begin
            p_nxt = P_HALF;
          end
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          p_nxt     = div_rsp.quot;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    inten_r   <= inten_nxt;
    upward_r  <= upward_nxt;
    cnt_r     <= cnt_nxt;
    minmode_r <= minmode_nxt;
    iss_r     <= iss_nxt;
    rcv_r     <= rcv_nxt;
    mn_r      <= mn_nxt;
    rank_r    <= rank_nxt;
    p_r       <= p_nxt;
  end

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.p_value        <= p_r;
      out_data_r.bin_used       <= 5'(bin_r);
      out_data_r.bin_population <= 13'(cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
